/* hw/rtl/bng_pkg.sv */
`default_nettype none

package bng_pkg;

  // sample and register widths
  localparam int unsigned SampleW    = 32;
  localparam int unsigned ThreshW    = 31;
  localparam int unsigned HoldW      = 16;
  localparam int unsigned CountW     = HoldW + 1;
  localparam int unsigned CfgIndexW  = 8;
  localparam int unsigned CfgDataW   = 32;

  // configuration register indexes
  typedef enum logic [CfgIndexW-1:0] {
    RegGateThreshold = 8'd0,
    RegHoldLimit     = 8'd1
  } reg_index_e;

  // reset values of the registers
  localparam logic [ThreshW-1:0] ThreshReset = 31'd262144;
  localparam logic [HoldW-1:0]   HoldReset   = 16'd256;

  // output queue entry
  typedef struct packed {
    logic [SampleW-1:0] data;
    logic               last;
  } out_word_t;

endpackage

`default_nettype wire

/* hw/rtl/block_noise_gate.sv */
`default_nettype none

// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata[31:0] sample_in (signed)
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata[31:0] sample_out, tlast block_last
// cfg       in   cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
// A sample is taken every cycle and stored in one half of a two-bank memory while
// the other half drains at one word per cycle, set by its single read port.
// The last sample of a block waits until the previous block is fully read;
// an output stall holds the drain and with it that last sample.
// Reset clears counters and flags; the memory needs no clearing pass.
module block_noise_gate #(
  parameter int unsigned BLOCK_LEN = 32
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  // s_axis tdata: [31:0] sample_in
  input  wire                                   s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire  signed [bng_pkg::SampleW-1:0]    s_axis_tdata,
  // m_axis tdata: [31:0] sample_out; tlast: block_last
  output logic                                  m_axis_tvalid,
  input  wire                                   m_axis_tready,
  output logic signed [bng_pkg::SampleW-1:0]    m_axis_tdata,
  output logic                                  m_axis_tlast,
  input  wire                                   cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire         [bng_pkg::CfgIndexW-1:0]  cfg_index_i,
  input  wire         [bng_pkg::CfgDataW-1:0]   cfg_data_i
);
  import bng_pkg::*;

  localparam int unsigned PosW     = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
  localparam int unsigned MemDepth = 2 * (1 << PosW);
  localparam logic [PosW-1:0] LastPos = PosW'(BLOCK_LEN - 1);

  // configuration registers
  logic [ThreshW-1:0] thresh_q;
  logic [HoldW-1:0]   hold_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= ThreshReset;
      hold_q   <= HoldReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegGateThreshold: thresh_q <= cfg_data_i[ThreshW-1:0];
        RegHoldLimit:     hold_q   <= cfg_data_i[HoldW-1:0];
        default: ;
      endcase
    end
  end

  // fill side state
  logic [PosW-1:0]   fill_pos_q, fill_pos_d;
  logic              fill_bank_q, fill_bank_d;
  logic              all_quiet_q, all_quiet_d;
  logic [CountW-1:0] count_q, count_d;

  // drain side state
  logic              drain_act_q, drain_act_d;
  logic              drain_bank_q, drain_bank_d;
  logic              drain_mute_q, drain_mute_d;
  logic [PosW-1:0]   drain_idx_q, drain_idx_d;

  // read pipeline and output queue
  logic              rd_pend_q;
  logic              rd_last_q;
  logic              rd_mute_q;
  logic [SampleW-1:0] rd_data_q;
  out_word_t         queue_q [2];
  out_word_t         queue_d [2];
  logic              wr_slot;
  logic [1:0]        cnt_q, cnt_d;

  logic              in_fire, fill_end, sample_quiet, quiet_block, mute;
  logic [CountW-1:0] count_inc, count_cap;
  logic              pop, push, issue;

  logic [SampleW-1:0] mem [MemDepth];

  // hold the block-final sample while the previous block still drains
  assign s_axis_tready = !((fill_pos_q == LastPos) && drain_act_q);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign fill_end      = in_fire && (fill_pos_q == LastPos);

  // signed compare against the threshold, gate count update
  assign sample_quiet = s_axis_tdata < $signed({1'b0, thresh_q});
  assign quiet_block  = all_quiet_q && sample_quiet;
  assign count_inc    = count_q + CountW'(1);
  assign count_cap    = {1'b0, hold_q} + CountW'(1);
  assign mute         = count_d > {1'b0, hold_q};

  always_comb begin
    fill_pos_d  = fill_pos_q;
    fill_bank_d = fill_bank_q;
    all_quiet_d = all_quiet_q;
    count_d     = count_q;
    if (in_fire) begin
      if (fill_end) begin
        fill_pos_d  = '0;
        fill_bank_d = !fill_bank_q;
        all_quiet_d = 1'b1;
        if (quiet_block) begin
          count_d = (count_inc > count_cap) ? count_cap : count_inc;
        end else begin
          count_d = '0;
        end
      end else begin
        fill_pos_d  = fill_pos_q + PosW'(1);
        all_quiet_d = quiet_block;
      end
    end
  end

  // issue a read when the queue has room for the word in flight
  assign pop   = m_axis_tvalid && m_axis_tready;
  assign push  = rd_pend_q;
  assign issue = drain_act_q &&
                 ((3'(cnt_q) + 3'(rd_pend_q) - 3'(pop)) <= 3'd1);

  always_comb begin
    drain_act_d  = drain_act_q;
    drain_bank_d = drain_bank_q;
    drain_mute_d = drain_mute_q;
    drain_idx_d  = drain_idx_q;
    if (issue) begin
      if (drain_idx_q == LastPos) begin
        drain_act_d = 1'b0;
        drain_idx_d = '0;
      end else begin
        drain_idx_d = drain_idx_q + PosW'(1);
      end
    end
    // start the drain of a completed block
    if (fill_end) begin
      drain_act_d  = 1'b1;
      drain_bank_d = fill_bank_q;
      drain_mute_d = mute;
      drain_idx_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_pos_q   <= '0;
      fill_bank_q  <= 1'b0;
      all_quiet_q  <= 1'b1;
      count_q      <= '0;
      drain_act_q  <= 1'b0;
      drain_bank_q <= 1'b0;
      drain_mute_q <= 1'b0;
      drain_idx_q  <= '0;
      rd_pend_q    <= 1'b0;
      cnt_q        <= '0;
    end else begin
      fill_pos_q   <= fill_pos_d;
      fill_bank_q  <= fill_bank_d;
      all_quiet_q  <= all_quiet_d;
      count_q      <= count_d;
      drain_act_q  <= drain_act_d;
      drain_bank_q <= drain_bank_d;
      drain_mute_q <= drain_mute_d;
      drain_idx_q  <= drain_idx_d;
      rd_pend_q    <= issue;
      cnt_q        <= cnt_d;
    end
  end

  // sample memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mem[{fill_bank_q, fill_pos_q}] <= s_axis_tdata;
    end
    if (issue) begin
      rd_data_q <= mem[{drain_bank_q, drain_idx_q}];
      rd_last_q <= (drain_idx_q == LastPos);
      rd_mute_q <= drain_mute_q;
    end
  end

  // two-word output queue, head in entry 0
  assign cnt_d   = cnt_q + 2'(push) - 2'(pop);
  assign wr_slot = (cnt_q == 2'd2) || ((cnt_q == 2'd1) && !pop);

  always_comb begin
    queue_d = queue_q;
    if (pop) begin
      queue_d[0] = queue_q[1];
    end
    if (push) begin
      queue_d[wr_slot].data = rd_mute_q ? '0 : rd_data_q;
      queue_d[wr_slot].last = rd_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    queue_q <= queue_d;
  end

  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = $signed(queue_q[0].data);
  assign m_axis_tlast  = queue_q[0].last;

endmodule

`default_nettype wire
